@@ rtl/core/pbsd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pbsd_pkg
// Types and constants shared by the port B bank switch decoder modules.
// ----------------------------------------------------------------------------
package pbsd_pkg;

   localparam int OFFSET_W      = 18;
   localparam int BANK_W        = 5;
   localparam int BANK_OFFSET_W = 14;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 8;

   localparam logic [1:0] OP_ACCESS = 2'd0;
   localparam logic [1:0] OP_PORTB  = 2'd1;
   localparam logic [1:0] OP_COLD   = 2'd2;

   localparam logic [2:0] TGT_RAM   = 3'd0;
   localparam logic [2:0] TGT_EXT   = 3'd1;
   localparam logic [2:0] TGT_OS    = 3'd2;
   localparam logic [2:0] TGT_SELF  = 3'd3;
   localparam logic [2:0] TGT_BASIC = 3'd4;
   localparam logic [2:0] TGT_DEV   = 3'd5;

   localparam logic [1:0] MODEL_XE     = 2'd1;
   localparam logic [1:0] MODEL_XE_320 = 2'd2;

   localparam logic [1:0] XRAM_MODE_BITS56 = 2'd1;
   localparam logic [1:0] XRAM_MODE_NO_ST  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MACHINE_MODEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_XRAM_MODE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASIC_LOCKED  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CART_PRESENT  = 2'd3;

   localparam logic [7:0] PORTB_COLD = 8'hFD;

   // Two's complement of the ROM and bank window bases on the offset adder.
   localparam logic [OFFSET_W-1:0] NEG_OS_BASE    = OFFSET_W'((1 << OFFSET_W) - 'hC000);
   localparam logic [OFFSET_W-1:0] NEG_SELF_BASE  = OFFSET_W'((1 << OFFSET_W) - 'h4000);
   localparam logic [OFFSET_W-1:0] NEG_BASIC_BASE = OFFSET_W'((1 << OFFSET_W) - 'hA000);
   localparam logic [OFFSET_W-1:0] NEG_BANK_SIZE  =
      OFFSET_W'((1 << OFFSET_W) - (1 << BANK_OFFSET_W));

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] address;
      logic        is_write;
      logic [7:0]  data;
   } req_type;

   typedef struct packed {
      logic [2:0]          target;
      logic [OFFSET_W-1:0] physical_offset;
      logic [2:0]          device_index;
      logic                write_allowed;
      logic [7:0]          write_data;
      logic [BANK_W-1:0]   current_bank;
   } rsp_type;

   typedef struct packed {
      logic os_on;
      logic basic_on;
      logic selftest_on;
      logic bank_active;
   } map_state_type;

endpackage
`default_nettype wire

@@ rtl/core/portb_bank_switch_decoder_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// portb_bank_switch_decoder_unit
// Memory map unit with port B bank switching for an 8-bit home computer.
// ----------------------------------------------------------------------------
// A bus access beat passes through ST_DECODE, which classifies the page, and
// ST_OFFSET, which forms the offset on the shared adder, before it reaches the
// response register. A port B write goes straight to ST_PB_APPLY, or, when it
// selects an extended bank on an XE model, first passes ST_PB_REDUCE, which
// subtracts BANK_COUNT from the raw bank number until it is below BANK_COUNT,
// and ST_PB_INC, which increments it, both on the same shared adder. Cold
// start and the unused operation are handled in ST_MISC. The request side is
// ready again in the cycle after the result is loaded, so no new access is
// accepted before the last one is through, and each beat takes longer while a
// finished result waits behind an earlier response that the consumer has not
// taken. The page map is held as region flags (OS, BASIC, self-test, bank
// window), so no clearing pass follows reset. A new request is taken whenever
// the sequencer is idle, even while a response still waits for the consumer.
module portb_bank_switch_decoder_unit #(
   parameter int BANK_COUNT = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire pbsd_pkg::req_type                   req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output pbsd_pkg::rsp_type                        rsp_payload,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pbsd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [pbsd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pbsd_pkg::*;

   localparam logic [BANK_W-1:0]   BANK_LIMIT = BANK_W'(BANK_COUNT);
   localparam logic [OFFSET_W-1:0] NEG_BANK   = OFFSET_W'((1 << OFFSET_W) - BANK_COUNT);
   localparam logic [OFFSET_W-1:0] ONE        = OFFSET_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_OFFSET,
      ST_PB_REDUCE,
      ST_PB_INC,
      ST_PB_APPLY,
      ST_MISC,
      ST_HOLD
   } state_type;

   state_type            state_ff, state_in;
   req_type              item_ff, item_in;
   logic [2:0]           tgt_ff, tgt_in;
   logic [OFFSET_W-1:0]  op_a_ff, op_a_in;
   logic [OFFSET_W-1:0]  op_b_ff, op_b_in;
   logic                 mask16_ff, mask16_in;
   logic [BANK_W-1:0]    acc_ff, acc_in;
   rsp_type              res_ff, res_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [7:0]           portb_ff, portb_in;
   logic [BANK_W-1:0]    ext_ff, ext_in;
   logic                 selftest_ff, selftest_in;
   logic                 basic_on_ff, basic_on_in;
   logic [1:0]           model_ff, model_in;
   logic [1:0]           xram_mode_ff, xram_mode_in;
   logic                 basic_locked_ff, basic_locked_in;
   logic                 cart_ff, cart_in;

   map_state_type        map_state;
   logic [2:0]           page_target;
   logic [OFFSET_W-1:0]  alu_a;
   logic [OFFSET_W-1:0]  alu_b;
   logic [OFFSET_W-1:0]  alu_sum;
   logic                 slot_free;
   logic                 model_is_xe;
   logic [3:0]           raw_bank;
   rsp_type              result;
   logic                 deliver;
   logic [7:0]           pb_new;
   logic [7:0]           pb_diff;
   logic                 bank_change;
   logic                 st_after_bank;
   logic                 st_after_os;
   logic                 st_final;

   assign map_state.os_on       = portb_ff[0];
   assign map_state.basic_on    = basic_on_ff;
   assign map_state.selftest_on = selftest_ff;
   assign map_state.bank_active = (ext_ff != '0);

   pbsd_page_decode u_page_decode (
      .page      (item_ff.address[15:8]),
      .map_state (map_state),
      .target    (page_target)
   );

   pbsd_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .sum  (alu_sum)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign model_is_xe = (model_ff == MODEL_XE) || (model_ff == MODEL_XE_320);

   always_comb begin
      if (model_ff == MODEL_XE_320) begin
         if (xram_mode_ff == XRAM_MODE_BITS56) begin
            raw_bank = {req_payload.data[6:5], req_payload.data[3:2]};
         end else begin
            raw_bank = {req_payload.data[7:6], req_payload.data[3:2]};
         end
      end else begin
         raw_bank = {2'b00, req_payload.data[3:2]};
      end
   end

   always_comb begin
      case (state_ff)
         ST_PB_REDUCE: begin
            alu_a = OFFSET_W'(acc_ff);
            alu_b = NEG_BANK;
         end
         ST_PB_INC: begin
            alu_a = OFFSET_W'(acc_ff);
            alu_b = ONE;
         end
         default: begin
            alu_a = op_a_ff;
            alu_b = op_b_ff;
         end
      endcase
   end

   always_comb begin
      pb_new        = item_ff.data;
      pb_diff       = portb_ff ^ pb_new;
      bank_change   = model_is_xe && (acc_ff != ext_ff);
      st_after_bank = selftest_ff && !bank_change;
      st_after_os   = st_after_bank && !(pb_diff[0] && !pb_new[0]);
      if (pb_new[7]) begin
         st_final = 1'b0;
      end else if (!st_after_os && pb_new[0] &&
                   (pb_new[4] || xram_mode_ff < XRAM_MODE_NO_ST)) begin
         st_final = 1'b1;
      end else begin
         st_final = st_after_os;
      end
   end

   always_comb begin
      state_in        = state_ff;
      item_in         = item_ff;
      tgt_in          = tgt_ff;
      op_a_in         = op_a_ff;
      op_b_in         = op_b_ff;
      mask16_in       = mask16_ff;
      acc_in          = acc_ff;
      res_in          = res_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      portb_in        = portb_ff;
      ext_in          = ext_ff;
      selftest_in     = selftest_ff;
      basic_on_in     = basic_on_ff;
      model_in        = model_ff;
      xram_mode_in    = xram_mode_ff;
      basic_locked_in = basic_locked_ff;
      cart_in         = cart_ff;
      result          = '0;
      result.current_bank = ext_ff;
      deliver         = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            CSR_MACHINE_MODEL: model_in        = csr_wdata[1:0];
            CSR_XRAM_MODE:     xram_mode_in    = csr_wdata[1:0];
            CSR_BASIC_LOCKED:  basic_locked_in = csr_wdata[0];
            CSR_CART_PRESENT:  cart_in         = csr_wdata[0];
            default:           model_in        = model_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_payload;
               case (req_payload.operation)
                  OP_ACCESS: state_in = ST_DECODE;
                  OP_PORTB: begin
                     if (model_is_xe && !req_payload.data[4]) begin
                        acc_in   = {1'b0, raw_bank};
                        state_in = ST_PB_REDUCE;
                     end else begin
                        acc_in   = '0;
                        state_in = ST_PB_APPLY;
                     end
                  end
                  default: state_in = ST_MISC;
               endcase
            end
         end
         ST_DECODE: begin
            tgt_in    = page_target;
            op_a_in   = OFFSET_W'(item_ff.address);
            op_b_in   = '0;
            mask16_in = 1'b0;
            case (page_target)
               TGT_EXT: begin
                  op_a_in = {ext_ff[3:0], item_ff.address[BANK_OFFSET_W-1:0]};
                  op_b_in = NEG_BANK_SIZE;
               end
               TGT_OS: begin
                  op_b_in   = NEG_OS_BASE;
                  mask16_in = 1'b1;
               end
               TGT_SELF: begin
                  op_b_in   = NEG_SELF_BASE;
                  mask16_in = 1'b1;
               end
               TGT_BASIC: begin
                  op_b_in   = NEG_BASIC_BASE;
                  mask16_in = 1'b1;
               end
               TGT_DEV: begin
                  op_a_in = OFFSET_W'(item_ff.address[7:0]);
               end
               default: begin
                  op_b_in = '0;
               end
            endcase
            state_in = ST_OFFSET;
         end
         ST_OFFSET: begin
            result.target = tgt_ff;
            result.physical_offset = mask16_ff ? OFFSET_W'(alu_sum[15:0]) : alu_sum;
            result.device_index = (tgt_ff == TGT_DEV) ? item_ff.address[10:8] : 3'd0;
            result.write_allowed = (tgt_ff == TGT_RAM) || (tgt_ff == TGT_EXT) ||
                                   (tgt_ff == TGT_DEV);
            result.write_data = item_ff.is_write ? item_ff.data : 8'd0;
            deliver = 1'b1;
         end
         ST_PB_REDUCE: begin
            if (acc_ff >= BANK_LIMIT) begin
               acc_in = alu_sum[BANK_W-1:0];
            end else begin
               state_in = ST_PB_INC;
            end
         end
         ST_PB_INC: begin
            acc_in   = alu_sum[BANK_W-1:0];
            state_in = ST_PB_APPLY;
         end
         ST_PB_APPLY: begin
            if (bank_change) begin
               ext_in = acc_ff;
            end
            if (!basic_locked_ff && pb_diff[1]) begin
               basic_on_in = !pb_new[1];
            end
            selftest_in = st_final;
            portb_in    = pb_new;
            result.current_bank = bank_change ? acc_ff : ext_ff;
            deliver = 1'b1;
         end
         ST_MISC: begin
            if (item_ff.operation == OP_COLD) begin
               portb_in    = PORTB_COLD;
               ext_in      = '0;
               selftest_in = 1'b0;
               basic_on_in = !cart_ff;
               result.current_bank = '0;
            end
            deliver = 1'b1;
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (deliver) begin
         res_in = result;
         if (slot_free) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         portb_ff        <= PORTB_COLD;
         ext_ff          <= '0;
         selftest_ff     <= 1'b0;
         basic_on_ff     <= 1'b1;
         model_ff        <= '0;
         xram_mode_ff    <= '0;
         basic_locked_ff <= 1'b0;
         cart_ff         <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         portb_ff        <= portb_in;
         ext_ff          <= ext_in;
         selftest_ff     <= selftest_in;
         basic_on_ff     <= basic_on_in;
         model_ff        <= model_in;
         xram_mode_ff    <= xram_mode_in;
         basic_locked_ff <= basic_locked_in;
         cart_ff         <= cart_in;
      end
      item_ff   <= item_in;
      tgt_ff    <= tgt_in;
      op_a_ff   <= op_a_in;
      op_b_ff   <= op_b_in;
      mask16_ff <= mask16_in;
      acc_ff    <= acc_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   a_bank_in_range: assert property (@(posedge clock) disable iff (reset)
      ext_ff <= BANK_LIMIT)
      else $error("Extended bank exceeds the bank count.");

   a_selftest_needs_os: assert property (@(posedge clock) disable iff (reset)
      selftest_ff |-> portb_ff[0])
      else $error("Self-test ROM is mapped while the OS ROM is off.");

   a_plain_model_keeps_bank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PB_APPLY && !model_is_xe) |=> $stable(ext_ff))
      else $error("Port B write changed the bank on a machine without banks.");

   a_cold_start_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MISC && item_ff.operation == OP_COLD) |=>
         (ext_ff == '0 && !selftest_ff && portb_ff == PORTB_COLD))
      else $error("Cold start left bank or self-test state behind.");

endmodule
`default_nettype wire

@@ rtl/core/pbsd_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pbsd_alu
// Shared adder used for address offsets, bank reduction and bank increment.
// ----------------------------------------------------------------------------
module pbsd_alu (
   input  wire logic [pbsd_pkg::OFFSET_W-1:0] op_a,
   input  wire logic [pbsd_pkg::OFFSET_W-1:0] op_b,
   output logic      [pbsd_pkg::OFFSET_W-1:0] sum
);
   import pbsd_pkg::*;

   assign sum = op_a + op_b;

endmodule
`default_nettype wire

@@ rtl/core/pbsd_page_decode.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pbsd_page_decode
// Classifies a 256-byte page into its target from the current map state.
// ----------------------------------------------------------------------------
module pbsd_page_decode (
   input  wire logic [7:0]                    page,
   input  wire pbsd_pkg::map_state_type       map_state,
   output logic      [2:0]                    target
);
   import pbsd_pkg::*;

   logic [2:0] bank_target;
   logic [2:0] os_target;

   always_comb begin
      bank_target = map_state.bank_active ? TGT_EXT : TGT_RAM;
      os_target   = map_state.os_on ? TGT_OS : TGT_RAM;
      if (page[7:6] == 2'b00) begin
         target = TGT_RAM;
      end else if (page[7:6] == 2'b01) begin
         if (page[5:4] == 2'b01 && map_state.selftest_on) begin
            target = TGT_SELF;
         end else begin
            target = bank_target;
         end
      end else if (page[7:5] == 3'b100) begin
         target = TGT_RAM;
      end else if (page[7:5] == 3'b101) begin
         target = map_state.basic_on ? TGT_BASIC : TGT_RAM;
      end else if (page[7:4] == 4'hC) begin
         target = os_target;
      end else if (page[7:3] == 5'b11010) begin
         target = TGT_DEV;
      end else begin
         target = os_target;
      end
   end

endmodule
`default_nettype wire
